/* hdl/tlik_pkg.sv */
// tlik_pkg: widths, types and the arctangent table of the two-link ik core
// used by every module in hdl; no dependencies
package tlik_pkg;

    localparam int X_W               = 20;
    localparam int L_W               = 19;
    localparam int ANG_W             = 16;
    localparam int M_W               = 41;
    localparam int ROOT_W            = 31;
    localparam int RAD_W             = 62;
    localparam int ROOT_SHIFT        = 22;
    localparam int MAG_W             = 64;
    localparam int CX_W              = 34;
    localparam int Z_W               = 32;
    localparam int ATAN_LEN          = 24;
    localparam int NORM_MSB          = 29;
    localparam int NORM_R            = 6;
    localparam int NORM_N            = 11;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam logic [L_W-1:0] LINK_RESET = L_W'(32768);

    typedef enum logic [1:0] {
        CFG_LINK1 = 2'd0,
        CFG_LINK2 = 2'd1
    } t_cfg_idx;

    // values that ride along the root pipeline
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [M_W-1:0] m;
        logic                  unreach;
    } t_sb;

    // shift of normalization stage k (1..NORM_N): right for the first NORM_R stages
    function automatic int norm_shift(input int k);
        if (k <= NORM_R) begin
            return 32 >> (k - 1);
        end
        return 16 >> (k - NORM_R - 1);
    endfunction

    function automatic logic [Z_W-1:0] atan_turn(input int i);
        logic [Z_W-1:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // binary angle in 2^-32 turn to 16 bit, rounded
    function automatic logic [ANG_W-1:0] to_bin16(input logic [Z_W-1:0] t);
        logic [Z_W-1:0] s;
        s = t + Z_W'(32768);
        return s[Z_W-1 -: ANG_W];
    endfunction

endpackage

/* hdl/tlik_front.sv */
// tlik_front: squares, products and reach test, four register stages
// depends on tlik_pkg
module tlik_front import tlik_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [X_W-1:0] i_x,
    input  logic signed [X_W-1:0] i_y,
    input  logic [L_W-1:0]        i_l1,
    input  logic [L_W-1:0]        i_l2,
    output logic                  o_valid,
    output logic [RAD_W-1:0]      o_va,
    output logic [RAD_W-1:0]      o_vb,
    output t_sb                   o_sb
);

    logic [3:0]                    r_vld;
    logic signed [X_W-1:0]         r_x [0:2];
    logic signed [X_W-1:0]         r_y [0:2];
    logic signed [2*X_W-1:0]       r_xx, r_yy;
    logic [2*L_W-1:0]              r_l11, r_l22, r_l12;
    logic [2*X_W-1:0]              r_r2;
    logic [2*L_W:0]                r_s, r_den, r_den3;
    logic signed [2*L_W:0]         r_d;
    logic signed [M_W-1:0]         r_n, r_m;
    logic [RAD_W-1:0]              r_va, r_vb;
    t_sb                           r_sb;
    logic signed [M_W:0]           w_dens, w_n, w_dm, w_dp;
    logic                          w_unreach;

    assign w_dens    = signed'({1'b0, (M_W-2*L_W-1)'(0), r_den3});
    assign w_n       = (M_W+1)'(r_n);
    assign w_dm      = w_dens - w_n;
    assign w_dp      = w_dens + w_n;
    assign w_unreach = (r_den3 == '0) || (w_n > w_dens) || (w_n < -w_dens);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: products
            r_xx   <= i_x * i_x;
            r_yy   <= i_y * i_y;
            r_l11  <= i_l1 * i_l1;
            r_l22  <= i_l2 * i_l2;
            r_l12  <= i_l1 * i_l2;
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            // stage 2: sums
            r_r2   <= $unsigned(r_xx) + $unsigned(r_yy);
            r_s    <= (2*L_W+1)'(r_l11) + (2*L_W+1)'(r_l22);
            r_d    <= signed'({1'b0, r_l11}) - signed'({1'b0, r_l22});
            r_den  <= {r_l12, 1'b0};
            r_x[1] <= r_x[0];
            r_y[1] <= r_y[0];
            // stage 3: numerators
            r_n    <= signed'(M_W'(r_r2)) - signed'(M_W'(r_s));
            r_m    <= signed'(M_W'(r_r2)) + M_W'(r_d);
            r_den3 <= r_den;
            r_x[2] <= r_x[1];
            r_y[2] <= r_y[1];
            // stage 4: reach test and root operands
            r_va       <= {w_dm[RAD_W-ROOT_SHIFT-1:0], ROOT_SHIFT'(0)};
            r_vb       <= {w_dp[RAD_W-ROOT_SHIFT-1:0], ROOT_SHIFT'(0)};
            r_sb.x       <= r_x[2];
            r_sb.y       <= r_y[2];
            r_sb.m       <= r_m;
            r_sb.unreach <= w_unreach;
        end
    end

    assign o_valid = r_vld[3];
    assign o_va    = r_va;
    assign o_vb    = r_vb;
    assign o_sb    = r_sb;

endmodule

/* hdl/tlik_sqrt.sv */
// tlik_sqrt: two floor square roots, one result bit per register stage
// depends on tlik_pkg
module tlik_sqrt import tlik_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_va,
    input  logic [RAD_W-1:0]  i_vb,
    input  t_sb               i_sb,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_a,
    output logic [ROOT_W-1:0] o_b,
    output t_sb               o_sb
);

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] q;
    } t_rs;

    function automatic t_rs root_step(input t_rs s, input int k);
        logic [RAD_W+1:0] trial;
        t_rs              res;
        trial = ((RAD_W+2)'(s.q) << (k + 1)) + ((RAD_W+2)'(1) << (2 * k));
        res   = s;
        if ({2'b00, s.rem} >= trial) begin
            res.rem = s.rem - trial[RAD_W-1:0];
            res.q   = s.q | (ROOT_W'(1) << k);
        end
        return res;
    endfunction

    logic [ROOT_W-1:0] r_vld;
    t_rs               r_a  [0:ROOT_W-1];
    t_rs               r_b  [0:ROOT_W-1];
    t_sb               r_sb [0:ROOT_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_st
        t_rs w_a, w_b;
        t_sb w_sb;
        if (j == 0) begin : g_first
            assign w_a  = '{rem: i_va, q: '0};
            assign w_b  = '{rem: i_vb, q: '0};
            assign w_sb = i_sb;
        end else begin : g_next
            assign w_a  = r_a[j-1];
            assign w_b  = r_b[j-1];
            assign w_sb = r_sb[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[j]  <= root_step(w_a, ROOT_W - 1 - j);
                r_b[j]  <= root_step(w_b, ROOT_W - 1 - j);
                r_sb[j] <= w_sb;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_a     = r_a[ROOT_W-1].q;
    assign o_b     = r_b[ROOT_W-1].q;
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

/* hdl/tlik_cordic.sv */
// tlik_cordic: pipelined atan2 in 2^-32 turn, staged normalization then vectoring
// depends on tlik_pkg
module tlik_cordic import tlik_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_tag,
    input  logic signed [MAG_W-1:0] i_y,
    input  logic signed [MAG_W-1:0] i_x,
    output logic                    o_valid,
    output logic                    o_tag,
    output logic [Z_W-1:0]          o_angle
);

    localparam int LAT = NORM_N + 2 + STAGES;

    logic [LAT-1:0]          r_vld, r_tag, r_zero;
    logic [NORM_N:0]         r_sx, r_sy;
    logic [MAG_W-1:0]        r_mx [0:NORM_N];
    logic [MAG_W-1:0]        r_my [0:NORM_N];
    logic signed [CX_W-1:0]  r_cx [0:STAGES];
    logic signed [CX_W-1:0]  r_cy [0:STAGES];
    logic [Z_W-1:0]          r_z  [0:STAGES];
    logic                    w_zero;
    logic                    w_flip;
    logic signed [CX_W-1:0]  w_mx, w_my;

    assign w_zero = (i_x == '0) && (i_y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag   <= {r_tag[LAT-2:0], i_tag};
            r_zero  <= {r_zero[LAT-2:0], w_zero};
            r_sx    <= {r_sx[NORM_N-1:0], i_x[MAG_W-1]};
            r_sy    <= {r_sy[NORM_N-1:0], i_y[MAG_W-1]};
            r_mx[0] <= i_x[MAG_W-1] ? MAG_W'(-i_x) : MAG_W'(i_x);
            r_my[0] <= i_y[MAG_W-1] ? MAG_W'(-i_y) : MAG_W'(i_y);
        end
    end

    for (genvar k = 1; k <= NORM_N; k++) begin : g_norm
        localparam int SH = norm_shift(k);
        logic [MAG_W-1:0] w_or;
        logic             w_do;
        assign w_or = r_mx[k-1] | r_my[k-1];
        if (k <= NORM_R) begin : g_right
            assign w_do = (w_or >> (NORM_MSB + SH)) != '0;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mx[k] <= w_do ? (r_mx[k-1] >> SH) : r_mx[k-1];
                    r_my[k] <= w_do ? (r_my[k-1] >> SH) : r_my[k-1];
                end
            end
        end else begin : g_left
            assign w_do = (w_or >> (NORM_MSB + 1 - SH)) == '0;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mx[k] <= w_do ? (r_mx[k-1] << SH) : r_mx[k-1];
                    r_my[k] <= w_do ? (r_my[k-1] << SH) : r_my[k-1];
                end
            end
        end
    end

    // fold the left half plane onto the right
    assign w_mx   = signed'(r_mx[NORM_N][CX_W-1:0]);
    assign w_my   = signed'(r_my[NORM_N][CX_W-1:0]);
    assign w_flip = r_sx[NORM_N] && (w_mx != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= w_mx;
            r_cy[0] <= (r_sy[NORM_N] ^ w_flip) ? -w_my : w_my;
            r_z[0]  <= w_flip ? {1'b1, (Z_W-1)'(0)} : '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        logic signed [CX_W-1:0] w_dx, w_dy;
        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][CX_W-1]) begin
                    r_cx[i+1] <= r_cx[i] + w_dx;
                    r_cy[i+1] <= r_cy[i] - w_dy;
                    r_z[i+1]  <= r_z[i] + atan_turn(i);
                end else begin
                    r_cx[i+1] <= r_cx[i] - w_dx;
                    r_cy[i+1] <= r_cy[i] + w_dy;
                    r_z[i+1]  <= r_z[i] - atan_turn(i);
                end
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_tag   = r_tag[LAT-1];
    assign o_angle = r_zero[LAT-1] ? '0 : r_z[STAGES];

endmodule

/* hdl/two_link_inverse_kinematics_core.sv */
// two_link_inverse_kinematics_core: joint angles of a two-link planar arm
// depends on tlik_pkg, tlik_front, tlik_sqrt, tlik_cordic
//
// channel   direction  handshake                 payload
// target    in         i_valid / o_stall         i_target_x, i_target_y
// angles    out        o_valid / i_stall         o_shoulder_angle, o_elbow_angle, o_unreachable
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while o_stall is low; the pipeline depth is
// set by the bit-per-stage square roots and the cordic stages
// i_rst_n is synchronous; it clears valid bits and the skid entry and loads LINK_RESET into the link lengths
// a stalled output parks one item in a skid register, then the whole pipeline holds
module two_link_inverse_kinematics_core import tlik_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [X_W-1:0]   i_target_x,
    input  logic signed [X_W-1:0]   i_target_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ANG_W-1:0] o_shoulder_angle,
    output logic signed [ANG_W-1:0] o_elbow_angle,
    output logic                    o_unreachable,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [L_W-1:0]          i_cfg_data
);

    logic [L_W-1:0]          r_link1, r_link2;
    logic                    w_en;
    logic                    w_f_vld, w_s_vld, w_c_vld, w_c_unr;
    logic [RAD_W-1:0]        w_va, w_vb;
    t_sb                     w_f_sb, w_s_sb;
    logic [ROOT_W-1:0]       w_a, w_b;
    logic                    r_p_vld;
    logic                    r_p_unr;
    logic [ROOT_W-1:0]       r_p_a, r_p_b;
    logic [2*ROOT_W-1:0]     r_p_ab;
    logic signed [MAG_W-1:0] r_p_mx;
    logic signed [X_W-1:0]   r_p_x, r_p_y;
    logic [Z_W-1:0]          w_z_elb, w_z_tgt, w_z_cor;
    logic                    w_d_vld;
    logic [ANG_W-1:0]        w_d_sh, w_d_el;
    logic                    w_d_unr;
    logic                    r_skid_v;
    logic [ANG_W-1:0]        r_skid_sh, r_skid_el;
    logic                    r_skid_unr;
    logic                    r_out_v;
    logic [ANG_W-1:0]        r_out_sh, r_out_el;
    logic                    r_out_unr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link1 <= LINK_RESET;
            r_link2 <= LINK_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LINK1: r_link1 <= i_cfg_data;
                CFG_LINK2: r_link2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;

    tlik_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_target_x),
        .i_y     (i_target_y),
        .i_l1    (r_link1),
        .i_l2    (r_link2),
        .o_valid (w_f_vld),
        .o_va    (w_va),
        .o_vb    (w_vb),
        .o_sb    (w_f_sb)
    );

    tlik_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_vld),
        .i_va    (w_va),
        .i_vb    (w_vb),
        .i_sb    (w_f_sb),
        .o_valid (w_s_vld),
        .o_a     (w_a),
        .o_b     (w_b),
        .o_sb    (w_s_sb)
    );

    // correction operands: a*b and m scaled by the root shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_ab  <= w_a * w_b;
            r_p_mx  <= MAG_W'(signed'({w_s_sb.m, ROOT_SHIFT'(0)}));
            r_p_a   <= w_a;
            r_p_b   <= w_b;
            r_p_x   <= w_s_sb.x;
            r_p_y   <= w_s_sb.y;
            r_p_unr <= w_s_sb.unreach;
        end
    end

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_vld),
        .i_tag   (r_p_unr),
        .i_y     (MAG_W'(r_p_y)),
        .i_x     (MAG_W'(r_p_x)),
        .o_valid (w_c_vld),
        .o_tag   (w_c_unr),
        .o_angle (w_z_tgt)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_elb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_vld),
        .i_tag   (r_p_unr),
        .i_y     (signed'(MAG_W'(r_p_a))),
        .i_x     (signed'(MAG_W'(r_p_b))),
        .o_valid (),
        .o_tag   (),
        .o_angle (w_z_elb)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_cor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p_vld),
        .i_tag   (r_p_unr),
        .i_y     (signed'(MAG_W'(r_p_ab))),
        .i_x     (r_p_mx),
        .o_valid (),
        .o_tag   (),
        .o_angle (w_z_cor)
    );

    assign w_d_vld = w_c_vld;
    assign w_d_unr = w_c_unr;
    assign w_d_el  = w_c_unr ? '0 : to_bin16({w_z_elb[Z_W-2:0], 1'b0});
    assign w_d_sh  = w_c_unr ? '0 : to_bin16(w_z_tgt - w_z_cor);

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_v <= w_d_vld;
        end else begin
            r_skid_v <= w_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out_sh  <= r_skid_sh;
                r_out_el  <= r_skid_el;
                r_out_unr <= r_skid_unr;
            end
        end else if (!r_out_v || !i_stall) begin
            r_out_sh  <= w_d_sh;
            r_out_el  <= w_d_el;
            r_out_unr <= w_d_unr;
        end else begin
            r_skid_sh  <= w_d_sh;
            r_skid_el  <= w_d_el;
            r_skid_unr <= w_d_unr;
        end
    end

    assign o_valid          = r_out_v;
    assign o_shoulder_angle = signed'(r_out_sh);
    assign o_elbow_angle    = signed'(r_out_el);
    assign o_unreachable    = r_out_unr;

endmodule
